FILE: hw/rtl/cn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cn_pkg: shared types and widths for the complex normalizer
// Word formats of the request and response channels and the internal widths
// of the divider and square root pipelines.
// ----------------------------------------------------------------------------
package cn_pkg;

   // Width of one part of the complex word
   localparam int DATA_WIDTH = 16;
   // Square of one part magnitude (at most 2^(2W-2))
   localparam int SQ_W       = 2 * DATA_WIDTH - 1;
   // Sum of squares
   localparam int SUM_W      = 2 * DATA_WIDTH;
   // Quotient a^2 * 2^(2W-2) / sum, at most 2^(2W-2)
   localparam int QUOT_W     = 2 * DATA_WIDTH - 1;
   // Root input and output widths
   localparam int ROOT_IN_W  = 2 * DATA_WIDTH;
   localparam int ROOT_W     = DATA_WIDTH;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] real_part;
      logic signed [DATA_WIDTH-1:0] imag_part;
   } req_type;

   typedef struct packed {
      logic        [DATA_WIDTH-1:0] magnitude_out;
      logic signed [DATA_WIDTH-1:0] unit_real;
      logic signed [DATA_WIDTH-1:0] unit_imag;
      logic                         zero_input;
   } rsp_type;

endpackage

FILE: hw/rtl/cn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cn_div: pipelined dual restoring divider
// Computes floor(num * 2^(QUOT_W-1) / den) for two numerators that share one
// denominator, one quotient bit per stage. Requires num <= den.
// ----------------------------------------------------------------------------
module cn_div #(
   parameter int SIDE_W = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [SIDE_W-1:0]         in_side,
   input  logic [cn_pkg::SQ_W-1:0]   num_a,
   input  logic [cn_pkg::SQ_W-1:0]   num_b,
   input  logic [cn_pkg::SUM_W-1:0]  den,
   output logic                      out_valid,
   output logic [SIDE_W-1:0]         out_side,
   output logic [cn_pkg::QUOT_W-1:0] quot_a,
   output logic [cn_pkg::QUOT_W-1:0] quot_b,
   output logic [cn_pkg::SUM_W-1:0]  out_den
);

   localparam int STEPS = cn_pkg::QUOT_W;
   localparam int REM_W = cn_pkg::SUM_W + 1;
   localparam int QW    = cn_pkg::QUOT_W;

   logic              valid_ff [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];
   logic [REM_W-1:0]  rem_a_ff [STEPS];
   logic [REM_W-1:0]  rem_b_ff [STEPS];
   logic [QW-1:0]     q_a_ff   [STEPS];
   logic [QW-1:0]     q_b_ff   [STEPS];
   logic [cn_pkg::SUM_W-1:0] den_ff [STEPS];

   genvar i;
   generate
      for (i = 0; i < STEPS; i++) begin : g_step
         logic                     v_in;
         logic [SIDE_W-1:0]        s_in;
         logic [REM_W-1:0]         ra_in, rb_in, ra_sh, rb_sh, d_ext;
         logic [QW-1:0]            qa_in, qb_in;
         logic [cn_pkg::SUM_W-1:0] d_in;
         logic                     ge_a, ge_b;

         // stage inputs: ports for the first step, previous stage otherwise
         if (i == 0) begin : g_first
            assign v_in  = in_valid;
            assign s_in  = in_side;
            assign ra_in = REM_W'(num_a);
            assign rb_in = REM_W'(num_b);
            assign qa_in = '0;
            assign qb_in = '0;
            assign d_in  = den;
            // integer quotient bit, no shift
            assign ra_sh = ra_in;
            assign rb_sh = rb_in;
         end else begin : g_next
            assign v_in  = valid_ff[i-1];
            assign s_in  = side_ff[i-1];
            assign ra_in = rem_a_ff[i-1];
            assign rb_in = rem_b_ff[i-1];
            assign qa_in = q_a_ff[i-1];
            assign qb_in = q_b_ff[i-1];
            assign d_in  = den_ff[i-1];
            assign ra_sh = {ra_in[REM_W-2:0], 1'b0};
            assign rb_sh = {rb_in[REM_W-2:0], 1'b0};
         end

         // compare and subtract
         assign d_ext = {1'b0, d_in};
         assign ge_a  = (ra_sh >= d_ext);
         assign ge_b  = (rb_sh >= d_ext);

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else begin
               valid_ff[i] <= v_in;
            end
            side_ff[i]  <= s_in;
            den_ff[i]   <= d_in;
            rem_a_ff[i] <= ge_a ? (ra_sh - d_ext) : ra_sh;
            rem_b_ff[i] <= ge_b ? (rb_sh - d_ext) : rb_sh;
            q_a_ff[i]   <= {qa_in[QW-2:0], ge_a};
            q_b_ff[i]   <= {qb_in[QW-2:0], ge_b};
         end
      end
   endgenerate

   assign out_valid = valid_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];
   assign quot_a    = q_a_ff[STEPS-1];
   assign quot_b    = q_b_ff[STEPS-1];
   assign out_den   = den_ff[STEPS-1];

endmodule

FILE: hw/rtl/cn_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cn_root: pipelined integer square root, several lanes
// Digit-by-digit restoring root, one result bit per stage; gives
// floor(sqrt(x)) for each lane with side bits carried alongside.
// ----------------------------------------------------------------------------
module cn_root #(
   parameter int LANES  = 3,
   parameter int IN_W   = cn_pkg::ROOT_IN_W,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [SIDE_W-1:0]     in_side,
   input  logic [IN_W-1:0]       x_in   [LANES],
   output logic                  out_valid,
   output logic [SIDE_W-1:0]     out_side,
   output logic [IN_W/2-1:0]     root_out [LANES]
);

   localparam int RW    = IN_W / 2;
   localparam int STEPS = RW;
   localparam int REM_W = RW + 2;

   logic              valid_ff [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];
   logic [IN_W-1:0]   x_ff     [STEPS][LANES];
   logic [REM_W-1:0]  rem_ff   [STEPS][LANES];
   logic [RW-1:0]     root_ff  [STEPS][LANES];

   genvar s, l;
   generate
      for (s = 0; s < STEPS; s++) begin : g_step
         logic              v_in;
         logic [SIDE_W-1:0] s_in;

         if (s == 0) begin : g_vfirst
            assign v_in = in_valid;
            assign s_in = in_side;
         end else begin : g_vnext
            assign v_in = valid_ff[s-1];
            assign s_in = side_ff[s-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else begin
               valid_ff[s] <= v_in;
            end
            side_ff[s] <= s_in;
         end

         for (l = 0; l < LANES; l++) begin : g_lane
            logic [IN_W-1:0]  x_cur;
            logic [REM_W-1:0] rem_cur, rem_sh, trial;
            logic [RW-1:0]    root_cur;
            logic             ge;

            if (s == 0) begin : g_first
               assign x_cur    = x_in[l];
               assign rem_cur  = '0;
               assign root_cur = '0;
            end else begin : g_next
               assign x_cur    = x_ff[s-1][l];
               assign rem_cur  = rem_ff[s-1][l];
               assign root_cur = root_ff[s-1][l];
            end

            // bring down the next two bits and try root*4+1
            assign rem_sh = {rem_cur[REM_W-3:0], x_cur[IN_W-1:IN_W-2]};
            assign trial  = {root_cur, 2'b01};
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge clock) begin
               x_ff[s][l]    <= {x_cur[IN_W-3:0], 2'b00};
               rem_ff[s][l]  <= ge ? (rem_sh - trial) : rem_sh;
               root_ff[s][l] <= {root_cur[RW-2:0], ge};
            end

            if (s == STEPS - 1) begin : g_out
               assign root_out[l] = root_ff[s][l];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

FILE: hw/rtl/complex_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_normalize: magnitude and unit-circle projection of a complex word
//
// Request: a word of signed real and imaginary parts on req_data is taken at
// each rising edge where start is high and busy is low. busy stays low, so
// a word may be issued every cycle.
// Response: rsp_valid is high for one cycle with rsp_data holding the
// magnitude floor(sqrt(re^2+im^2)), each part divided by that exact
// magnitude in Q1.15 truncated toward zero (+1.0 saturates to 32767), and
// the zero flag (all outputs zero for a zero input). The receiver cannot
// stall; every response must be taken in the cycle it is shown.
// Throughput: one word per cycle. The word passes 51 register stages: 3 of
// sign removal, squaring and sum, 31 of the shared-denominator divider
// (one quotient bit each), 16 of square root (one root bit each) and one
// output stage.
// Reset clears all valid bits; words in flight are dropped.
// ----------------------------------------------------------------------------
module complex_normalize (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  cn_pkg::req_type req_data,
   output logic            rsp_valid,
   output cn_pkg::rsp_type rsp_data
);

   localparam int DW = cn_pkg::DATA_WIDTH;

   typedef struct packed {
      logic real_neg;
      logic imag_neg;
      logic zero;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   // stage A: sign and magnitude of each part
   logic          a_valid_ff;
   logic [DW-1:0] a_re_ff, a_im_ff;
   logic          a_rneg_ff, a_ineg_ff;
   // stage B: squares
   logic                   b_valid_ff;
   logic [cn_pkg::SQ_W-1:0] b_sqr_ff, b_sqi_ff;
   logic                   b_rneg_ff, b_ineg_ff;
   // stage C: sum of squares
   logic                    c_valid_ff;
   logic [cn_pkg::SUM_W-1:0] c_sum_ff;
   logic [cn_pkg::SQ_W-1:0]  c_sqr_ff, c_sqi_ff;
   side_type                c_side_ff;

   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      // absolute values; most negative maps to 2^(W-1) unsigned
      a_rneg_ff <= req_data.real_part[DW-1];
      a_ineg_ff <= req_data.imag_part[DW-1];
      a_re_ff   <= req_data.real_part[DW-1] ? (~req_data.real_part + 1'b1)
                                            : req_data.real_part;
      a_im_ff   <= req_data.imag_part[DW-1] ? (~req_data.imag_part + 1'b1)
                                            : req_data.imag_part;
      // squares
      b_rneg_ff <= a_rneg_ff;
      b_ineg_ff <= a_ineg_ff;
      b_sqr_ff  <= cn_pkg::SQ_W'(a_re_ff * a_re_ff);
      b_sqi_ff  <= cn_pkg::SQ_W'(a_im_ff * a_im_ff);
      // sum and zero detect
      c_sum_ff           <= cn_pkg::SUM_W'(b_sqr_ff) + cn_pkg::SUM_W'(b_sqi_ff);
      c_sqr_ff           <= b_sqr_ff;
      c_sqi_ff           <= b_sqi_ff;
      c_side_ff.real_neg <= b_rneg_ff;
      c_side_ff.imag_neg <= b_ineg_ff;
      c_side_ff.zero     <= (b_sqr_ff == '0) && (b_sqi_ff == '0);
   end

   // divider: a^2 * 2^(2W-2) / sum for both parts
   logic                      d_valid;
   logic [SIDE_W-1:0]         d_side;
   logic [cn_pkg::QUOT_W-1:0] d_qr, d_qi;
   logic [cn_pkg::SUM_W-1:0]  d_sum;

   cn_div #(
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_side   (c_side_ff),
      .num_a     (c_sqr_ff),
      .num_b     (c_sqi_ff),
      .den       (c_sum_ff),
      .out_valid (d_valid),
      .out_side  (d_side),
      .quot_a    (d_qr),
      .quot_b    (d_qi),
      .out_den   (d_sum)
   );

   // roots: magnitude, and sqrt of each quotient gives the unit part
   logic [cn_pkg::ROOT_IN_W-1:0] r_in  [3];
   logic [cn_pkg::ROOT_W-1:0]    r_out [3];
   logic                         r_valid;
   logic [SIDE_W-1:0]            r_side_bits;
   side_type                     r_side;

   assign r_in[0] = d_sum;
   assign r_in[1] = cn_pkg::ROOT_IN_W'(d_qr);
   assign r_in[2] = cn_pkg::ROOT_IN_W'(d_qi);

   cn_root #(
      .LANES  (3),
      .IN_W   (cn_pkg::ROOT_IN_W),
      .SIDE_W (SIDE_W)
   ) u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_side   (d_side),
      .x_in      (r_in),
      .out_valid (r_valid),
      .out_side  (r_side_bits),
      .root_out  (r_out)
   );

   assign r_side = side_type'(r_side_bits);

   // output stage: sign restore, +1.0 saturation, zero override
   logic [DW-1:0] ur_in, ui_in;
   logic          rsp_valid_ff;
   cn_pkg::rsp_type rsp_ff;

   always_comb begin
      if (r_side.real_neg) begin
         ur_in = ~r_out[1] + 1'b1;
      end else if (r_out[1][DW-1]) begin
         ur_in = {1'b0, {(DW-1){1'b1}}};
      end else begin
         ur_in = r_out[1];
      end
      if (r_side.imag_neg) begin
         ui_in = ~r_out[2] + 1'b1;
      end else if (r_out[2][DW-1]) begin
         ui_in = {1'b0, {(DW-1){1'b1}}};
      end else begin
         ui_in = r_out[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= r_valid;
      end
      if (r_side.zero) begin
         rsp_ff.magnitude_out <= '0;
         rsp_ff.unit_real     <= '0;
         rsp_ff.unit_imag     <= '0;
         rsp_ff.zero_input    <= 1'b1;
      end else begin
         rsp_ff.magnitude_out <= r_out[0];
         rsp_ff.unit_real     <= ur_in;
         rsp_ff.unit_imag     <= ui_in;
         rsp_ff.zero_input    <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
